### rtl/swdh_pkg.sv
// shared types, codes and bit-pattern helpers for the swd host transfer engine
// no dependencies

package swdh_pkg;

  typedef logic [3:0] phase_t;

  localparam phase_t PH_IDLE  = 4'd0;
  localparam phase_t PH_REQ   = 4'd1;
  localparam phase_t PH_ACK   = 4'd2;
  localparam phase_t PH_RDATA = 4'd3;
  localparam phase_t PH_WTURN = 4'd4;
  localparam phase_t PH_WDATA = 4'd5;
  localparam phase_t PH_TURN  = 4'd6;
  localparam phase_t PH_TAIL  = 4'd7;
  localparam phase_t PH_CONN  = 4'd8;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_XFER  = 2'd1;
  localparam logic [1:0] REQ_CONN  = 2'd2;
  localparam logic [1:0] REQ_RESET = 2'd3;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_WAIT   = 2'd1;
  localparam logic [1:0] STAT_FAULT  = 2'd2;
  localparam logic [1:0] STAT_PARITY = 2'd3;

  localparam logic [2:0] ACK_OK   = 3'd1;
  localparam logic [2:0] ACK_WAIT = 3'd2;

  localparam logic [15:0] SWITCH_SEQ = 16'hE79E;
  localparam logic [7:0]  REQ_LEN    = 8'd8;
  localparam logic [7:0]  ACK_LEN    = 8'd3;
  localparam logic [7:0]  IDLE_LEN   = 8'd8;
  localparam logic [7:0]  ONES_LEN   = 8'd56;
  localparam logic [7:0]  SEQ_LEN    = 8'd16;
  localparam logic [7:0]  DATA_LEN   = 8'd32;
  localparam logic [7:0]  TURN_LEN   = 8'd2;
  localparam logic [7:0]  SEQ_START  = IDLE_LEN + ONES_LEN;
  localparam logic [7:0]  ONES2_START = SEQ_START + SEQ_LEN;
  localparam logic [7:0]  TAIL_START = ONES2_START + ONES_LEN;
  localparam logic [7:0]  CONN_LEN   = TAIL_START + IDLE_LEN;

  localparam logic [7:0] MAX_ATTEMPTS_RST = 8'd16;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  slot;
    logic [32:0] shift;
    logic [2:0]  ack;
    logic [7:0]  attempts;
    logic [3:0]  req;
    logic [31:0] data;
    logic        reset_line;
    logic        line_state;
  } eng_state_t;

  typedef struct packed {
    logic [31:0] read_word;
    logic [2:0]  ack_bits;
    logic [1:0]  status;
    logic        done;
    logic        busy;
    logic        reset_drive_low;
    logic        line_drive_low;
    logic        clock_pulse;
  } eng_res_t;

  // request latch: bit0 apndp, bit1 rnw, bits 3:2 a3:a2
  function automatic logic [7:0] request_byte(input logic [3:0] req);
    logic par;
    par = ^req;
    return {1'b1, 1'b0, par, req[3], req[2], req[1], req[0], 1'b1};
  endfunction

  function automatic logic connect_bit(input logic [7:0] s);
    logic b;
    if (s < IDLE_LEN) begin
      b = 1'b0;
    end else if (s < SEQ_START) begin
      b = 1'b1;
    end else if (s < ONES2_START) begin
      b = SWITCH_SEQ[s[3:0]];
    end else if (s < TAIL_START) begin
      b = 1'b1;
    end else begin
      b = 1'b0;
    end
    return b;
  endfunction

endpackage

### rtl/swdh_step.sv
// one bit-slot step of the swd sequencer: next state and result for one item
// depends on swdh_pkg

module swdh_step (
  input  swdh_pkg::eng_state_t cur,
  input  logic [1:0]           req_type,
  input  logic                 ap_not_dp,
  input  logic                 read_not_write,
  input  logic [1:0]           reg_select,
  input  logic [31:0]          write_word,
  input  logic                 line_sample,
  input  logic                 hold_reset,
  input  logic [7:0]           max_attempts,
  output swdh_pkg::eng_state_t nxt,
  output swdh_pkg::eng_res_t   res
);
  import swdh_pkg::*;

  logic [3:0]  ack_tmp;
  logic [7:0]  slot_inc;
  logic        clk_p;
  logic        done;
  logic [1:0]  status;
  logic [2:0]  ack_out;
  logic [31:0] rword;
  logic [7:0]  req_byte;

  assign ack_tmp  = {1'b0, cur.ack} | (4'(line_sample) << cur.slot[1:0]);
  assign slot_inc = cur.slot + 8'd1;
  assign req_byte = request_byte(cur.req);

  always_comb begin
    nxt     = cur;
    clk_p   = 1'b0;
    done    = 1'b0;
    status  = STAT_OK;
    ack_out = 3'd0;
    rword   = 32'd0;
    if (req_type != REQ_TICK) begin
      if (cur.phase == PH_IDLE) begin
        case (req_type)
          REQ_XFER: begin
            nxt.req      = {reg_select, read_not_write, ap_not_dp};
            nxt.data     = write_word;
            nxt.attempts = (max_attempts == 8'd0) ? 8'd1 : max_attempts;
            nxt.phase    = PH_REQ;
            nxt.slot     = 8'd0;
            nxt.ack      = 3'd0;
            nxt.shift    = 33'd0;
          end
          REQ_CONN: begin
            nxt.phase = PH_CONN;
            nxt.slot  = 8'd0;
          end
          REQ_RESET: nxt.reset_line = hold_reset;
          default: ;
        endcase
      end
    end else if (cur.phase != PH_IDLE) begin
      clk_p    = 1'b1;
      nxt.slot = slot_inc;
      unique case (cur.phase)
        PH_REQ: begin
          nxt.line_state = ~req_byte[cur.slot[2:0]];
          if (slot_inc >= REQ_LEN) begin
            nxt.phase = PH_ACK;
            nxt.slot  = 8'd0;
          end
        end
        PH_ACK: begin
          nxt.line_state = 1'b0;
          nxt.ack        = ack_tmp[2:0];
          if (slot_inc >= ACK_LEN) begin
            nxt.slot = 8'd0;
            if (ack_tmp[2:0] == ACK_OK) begin
              nxt.phase = cur.req[1] ? PH_RDATA : PH_WTURN;
            end else begin
              nxt.phase = PH_TURN;
            end
          end
        end
        PH_RDATA: begin
          nxt.line_state = 1'b0;
          nxt.shift      = cur.shift | (33'(line_sample) << cur.slot[5:0]);
          if (slot_inc >= DATA_LEN + 8'd1) begin
            nxt.phase = PH_TURN;
            nxt.slot  = 8'd0;
          end
        end
        PH_WTURN: begin
          nxt.line_state = 1'b0;
          if (slot_inc >= TURN_LEN) begin
            nxt.phase = PH_WDATA;
            nxt.slot  = 8'd0;
          end
        end
        PH_WDATA: begin
          nxt.line_state = (cur.slot < DATA_LEN) ? ~cur.data[cur.slot[4:0]] : ~(^cur.data);
          if (slot_inc >= DATA_LEN + 8'd1) begin
            nxt.phase = PH_TAIL;
            nxt.slot  = 8'd0;
          end
        end
        PH_TURN: begin
          nxt.line_state = 1'b0;
          if (slot_inc >= TURN_LEN) begin
            nxt.phase = PH_TAIL;
            nxt.slot  = 8'd0;
          end
        end
        PH_TAIL: begin
          nxt.line_state = 1'b1;
          if (slot_inc >= IDLE_LEN) begin
            if (cur.ack == ACK_WAIT && cur.attempts > 8'd1) begin
              nxt.attempts = cur.attempts - 8'd1;
              nxt.phase    = PH_REQ;
              nxt.slot     = 8'd0;
              nxt.ack      = 3'd0;
              nxt.shift    = 33'd0;
            end else begin
              nxt.phase = PH_IDLE;
              nxt.slot  = 8'd0;
              done      = 1'b1;
              ack_out   = cur.ack;
              if (cur.ack == ACK_OK) begin
                if (cur.req[1]) begin
                  if ((^cur.shift[31:0]) != cur.shift[32]) begin
                    status = STAT_PARITY;
                  end else begin
                    rword = cur.shift[31:0];
                  end
                end
              end else if (cur.ack == ACK_WAIT) begin
                status = STAT_WAIT;
              end else begin
                status = STAT_FAULT;
              end
            end
          end
        end
        PH_CONN: begin
          nxt.line_state = ~connect_bit(cur.slot);
          if (slot_inc >= CONN_LEN) begin
            nxt.phase = PH_IDLE;
            nxt.slot  = 8'd0;
            done      = 1'b1;
          end
        end
        default: begin
          nxt.phase = PH_IDLE;
          nxt.slot  = 8'd0;
          clk_p     = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    res.clock_pulse     = clk_p;
    res.line_drive_low  = nxt.line_state;
    res.reset_drive_low = nxt.reset_line;
    res.busy            = (nxt.phase != PH_IDLE);
    res.done            = done;
    res.status          = status;
    res.ack_bits        = ack_out;
    res.read_word       = rword;
  end

endmodule

### rtl/swd_host_transfer_engine_unit.sv
// top level of the swd host transfer engine: sequencer state and result register
// depends on swdh_pkg and swdh_step
//
// usage: each input transfer is one item. in_tuser selects the kind: a tick
// (one SWCLK bit slot), start of a read/write transfer, start of the connect
// sequence, or a set of the NRST line. commands are ignored while a sequence
// runs. every item gives exactly one result on the out_ channel: whether the
// slot pulses SWCLK, the SWDIO and NRST levels to hold, busy, and on the last
// slot of a transfer or connect out_tlast with status, raw ack and read data.
// the result is valid in the cycle after its input; one item is taken every
// cycle unless a stalled result holds in_tready low, sequencer state and result
// register being the only stages. a transfer takes 21 to 54 ticks per attempt,
// connect 144 ticks. max_attempts is written via cfg_wr_en and cfg_wr_data;
// the user must write it only while idle, the block does not enforce this.
// reset (rst_n low, synchronous) returns the sequencer to idle with SWDIO and
// NRST released, max_attempts 16, no result pending. when the receiver stalls,
// the result is held and in_tready drops until it is taken; no item is lost.

module swd_host_transfer_engine_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  // ap_not_dp, read_not_write, reg_select[1:0], write_word[31:0], line_sample,
  // hold_reset, zero pad
  input  logic [39:0] in_tdata,
  // req_type[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // clock_pulse, line_drive_low, reset_drive_low, busy_res, status[1:0],
  // ack_bits[2:0], read_word[31:0], zero pad
  output logic [47:0] out_tdata,
  // done_res
  output logic        out_tlast
);
  import swdh_pkg::*;

  eng_state_t state_r;
  eng_state_t state_nxt;
  eng_res_t   res_r;
  eng_res_t   res_nxt;
  logic       out_valid_r;
  logic [7:0] max_att_r;
  logic       in_fire;

  assign in_tready = ~out_valid_r | out_tready;
  assign in_fire   = in_tvalid & in_tready;

  swdh_step u_step (
    .cur            (state_r),
    .req_type       (in_tuser),
    .ap_not_dp      (in_tdata[0]),
    .read_not_write (in_tdata[1]),
    .reg_select     (in_tdata[3:2]),
    .write_word     (in_tdata[35:4]),
    .line_sample    (in_tdata[36]),
    .hold_reset     (in_tdata[37]),
    .max_attempts   (max_att_r),
    .nxt            (state_nxt),
    .res            (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_att_r <= MAX_ATTEMPTS_RST;
    end else if (cfg_wr_en) begin
      max_att_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = res_r.done;
  assign out_tdata  = {7'd0, res_r.read_word, res_r.ack_bits, res_r.status, res_r.busy,
                       res_r.reset_drive_low, res_r.line_drive_low, res_r.clock_pulse};

endmodule

### rtl/swdh_checker.sv
// port-level checks for the swd host transfer engine, bound to the top level
// depends on swdh_pkg and swd_host_transfer_engine_unit port names

module swdh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic        out_tlast
);
  import swdh_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // an empty result register never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with no pending result");

  // the last slot is a clocked slot that leaves the engine idle
  a_done_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[0] && !out_tdata[3])
    else $error("done on a non-clocked or busy slot");

  // status, ack and read word stay zero outside the last slot
  a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[40:4] == 37'd0)
    else $error("result fields set outside done");

  // a command item never pulses the clock
  a_cmd_no_clk: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser != REQ_TICK |=> out_tvalid && !out_tdata[0])
    else $error("clock pulse on a command item");

endmodule

bind swd_host_transfer_engine_unit swdh_checker u_swdh_checker (.*);
